/* sv/ffha_pkg.sv */
// Shared widths, status codes and helpers for the first-fit heap allocator.
package ffha_pkg;

    localparam int unsigned ARENA_BYTES_DEF  = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 32;

    // Offsets and sizes never pass 65536, so 17 bits hold them.
    localparam int unsigned OFS_W  = 17;
    localparam int unsigned SIZE_W = 17;
    localparam int unsigned TAG_W  = SIZE_W + 1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_ZERO    = 2'd1;
    localparam status_t ST_NOSPACE = 2'd2;
    localparam status_t ST_BADFREE = 2'd3;

    // Tag entry: free flag above the payload size.
    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } tag_t;

    // Round a request up to a multiple of 8 bytes.
    function automatic logic [OFS_W:0] round8(input logic [OFS_W-1:0] req);
        logic [OFS_W:0] sum;
        sum = {1'b0, req} + (OFS_W+1)'(7);
        return {sum[OFS_W:3], 3'b000};
    endfunction

endpackage

/* sv/first_fit_heap_allocator.sv */
// First-fit heap allocator with block splitting and coalescing over a tag memory.
//
// Usage: present an item on s_valid/s_ready (s_kind 0 allocate with
// s_request_bytes, 1 free with s_free_address). Each item yields exactly one
// result transfer on m_valid/m_ready carrying m_payload_address and m_status.
// The limit register is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce;
// cfg_ready is always high. Tags live in a memory indexed by block start / 8;
// blocks are walked in address order from offset zero, each block header taking
// a memory read state and then an evaluate state. An allocate ends by taking a
// fitting free block, with a further write when it splits off the remainder, or
// by extending the break; a free walks up to the target block, then reads the
// successor when one lies below the break, and merges. A zero-size request answers
// without a walk. Items are handled one at a time.
// Reset empties the heap (break at zero) and sets the limit to 65536; the
// tag memory needs no clearing, as entries past the break are never read.
// The result sits in an output register; a new item is taken while it
// waits, but a finished result holds the walker until the register empties.
module first_fit_heap_allocator #(
    parameter int unsigned ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [16:0]                 s_request_bytes,
    input  logic [15:0]                 s_free_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_payload_address,
    output ffha_pkg::status_t           m_status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [16:0]                 cfg_data
);
    import ffha_pkg::*;

    localparam int unsigned CEIL_BYTES = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
    localparam int unsigned DEPTH      = CEIL_BYTES / 8;
    localparam int unsigned AW         = $clog2(DEPTH);
    localparam logic [OFS_W:0] HDR     = (OFS_W+1)'(HEADER_BYTES);
    localparam logic [OFS_W:0] CEIL    = (OFS_W+1)'(CEIL_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EV, S_NRD, S_NEV, S_MRG, S_WR2, S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [OFS_W-1:0]    limit_reg, limit_next;
    logic [OFS_W-1:0]    top_reg, top_next;
    logic [OFS_W-1:0]    cur_reg, cur_next;      // start of block under walk
    logic [OFS_W-1:0]    raddr_reg, raddr_next;  // start being read
    logic                kind_reg, kind_next;
    logic [OFS_W:0]      need_reg, need_next;
    logic [15:0]         faddr_reg, faddr_next;
    logic [SIZE_W-1:0]   sz_reg, sz_next;        // size of the block being freed
    logic                pv_reg, pv_next;        // predecessor exists
    logic                pfree_reg, pfree_next;
    logic [OFS_W-1:0]    pst_reg, pst_next;
    logic [SIZE_W-1:0]   psz_reg, psz_next;
    logic [OFS_W-1:0]    wa2_reg, wa2_next;      // split remainder
    logic [SIZE_W-1:0]   ws2_reg, ws2_next;
    logic [15:0]         raddr_out_reg, raddr_out_next;
    status_t             rst_reg, rst_next;
    logic                mv_reg, mv_next;
    logic [15:0]         mpa_reg, mpa_next;
    status_t             mst_reg, mst_next;

    logic                we;
    logic [OFS_W-1:0]    wofs;
    tag_t                wdata, rdata;

    logic [OFS_W:0]      ceil_w, end_cur, ext_end, mrg_end;
    logic [OFS_W:0]      rem_w, msz_w;
    logic [OFS_W-1:0]    mst_ofs;

    ffha_tag_ram #(.DEPTH(DEPTH), .AW(AW)) u_tags (
        .aclk  (aclk),
        .we    (we),
        .waddr (wofs[AW+2:3]),
        .wdata (wdata),
        .raddr (raddr_reg[AW+2:3]),
        .rdata (rdata)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = mv_reg;
    assign m_payload_address = mpa_reg;
    assign m_status          = mst_reg;

    always_comb begin
        ceil_w  = ({1'b0, limit_reg} < CEIL) ? {1'b0, limit_reg} : CEIL;
        end_cur = {1'b0, cur_reg} + HDR + {1'b0, rdata.size};
        ext_end = {1'b0, top_reg} + HDR + need_reg;
        rem_w   = {1'b0, rdata.size} - need_reg;
        // Merge with a free predecessor where there is one.
        if (pv_reg && pfree_reg) begin
            msz_w   = {1'b0, psz_reg} + {1'b0, sz_reg} + HDR;
            mst_ofs = pst_reg;
        end else begin
            msz_w   = {1'b0, sz_reg};
            mst_ofs = cur_reg;
        end
        mrg_end = {1'b0, mst_ofs} + HDR + msz_w;
    end

    always_comb begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        top_next       = top_reg;
        cur_next       = cur_reg;
        raddr_next     = raddr_reg;
        kind_next      = kind_reg;
        need_next      = need_reg;
        faddr_next     = faddr_reg;
        sz_next        = sz_reg;
        pv_next        = pv_reg;
        pfree_next     = pfree_reg;
        pst_next       = pst_reg;
        psz_next       = psz_reg;
        wa2_next       = wa2_reg;
        ws2_next       = ws2_reg;
        raddr_out_next = raddr_out_reg;
        rst_next       = rst_reg;
        mv_next        = mv_reg;
        mpa_next       = mpa_reg;
        mst_next       = mst_reg;
        we             = 1'b0;
        wofs           = cur_reg;
        wdata          = '{is_free: 1'b0, size: rdata.size};

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next      = s_kind;
                    need_next      = round8(s_request_bytes);
                    faddr_next     = s_free_address;
                    cur_next       = '0;
                    raddr_next     = '0;
                    pv_next        = 1'b0;
                    raddr_out_next = '0;
                    if (!s_kind && s_request_bytes == '0) begin
                        rst_next   = ST_ZERO;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                if (cur_reg >= top_reg) begin
                    // Walk reached the break.
                    if (kind_reg) begin
                        rst_next = ST_BADFREE;
                    end else if (ext_end > ceil_w) begin
                        rst_next = ST_NOSPACE;
                    end else begin
                        we             = 1'b1;
                        wofs           = top_reg;
                        wdata          = '{is_free: 1'b0, size: need_reg[SIZE_W-1:0]};
                        top_next       = ext_end[OFS_W-1:0];
                        raddr_out_next = 16'(({1'b0, top_reg} + HDR));
                        rst_next       = ST_OK;
                    end
                    state_next = S_FIN;
                end else if (!kind_reg && rdata.is_free && {1'b0, rdata.size} >= need_reg) begin
                    we             = 1'b1;
                    wofs           = cur_reg;
                    raddr_out_next = 16'(({1'b0, cur_reg} + HDR));
                    rst_next       = ST_OK;
                    if (rem_w >= HDR + (OFS_W+1)'(8)) begin
                        wdata      = '{is_free: 1'b0, size: need_reg[SIZE_W-1:0]};
                        wa2_next   = OFS_W'({1'b0, cur_reg} + HDR + need_reg);
                        ws2_next   = SIZE_W'(rem_w - HDR);
                        state_next = S_WR2;
                    end else begin
                        state_next = S_FIN;
                    end
                end else if (kind_reg && !rdata.is_free
                             && {1'b0, cur_reg} + HDR == {2'b00, faddr_reg}) begin
                    sz_next    = rdata.size;
                    raddr_next = end_cur[OFS_W-1:0];
                    state_next = (end_cur[OFS_W-1:0] < top_reg) ? S_NRD : S_MRG;
                end else begin
                    // Advance to the next block.
                    pv_next    = 1'b1;
                    pfree_next = rdata.is_free;
                    pst_next   = cur_reg;
                    psz_next   = rdata.size;
                    cur_next   = end_cur[OFS_W-1:0];
                    raddr_next = end_cur[OFS_W-1:0];
                    state_next = S_RD;
                end
            end
            S_NRD: begin
                state_next = S_NEV;
            end
            S_NEV: begin
                if (rdata.is_free) begin
                    sz_next = SIZE_W'({1'b0, sz_reg} + {1'b0, rdata.size} + HDR);
                end
                state_next = S_MRG;
            end
            S_MRG: begin
                if (mrg_end[OFS_W-1:0] == top_reg) begin
                    // Drop the trailing free block.
                    top_next = mst_ofs;
                end else begin
                    we    = 1'b1;
                    wofs  = mst_ofs;
                    wdata = '{is_free: 1'b1, size: msz_w[SIZE_W-1:0]};
                end
                rst_next   = ST_OK;
                state_next = S_FIN;
            end
            S_WR2: begin
                we         = 1'b1;
                wofs       = wa2_reg;
                wdata      = '{is_free: 1'b1, size: ws2_reg};
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mst_next   = rst_reg;
                    mpa_next   = (rst_reg == ST_OK && !kind_reg) ? raddr_out_reg : 16'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            limit_reg <= 17'h10000;
            top_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            top_reg   <= top_next;
            mv_reg    <= mv_next;
        end
        cur_reg       <= cur_next;
        raddr_reg     <= raddr_next;
        kind_reg      <= kind_next;
        need_reg      <= need_next;
        faddr_reg     <= faddr_next;
        sz_reg        <= sz_next;
        pv_reg        <= pv_next;
        pfree_reg     <= pfree_next;
        pst_reg       <= pst_next;
        psz_reg       <= psz_next;
        wa2_reg       <= wa2_next;
        ws2_reg       <= ws2_next;
        raddr_out_reg <= raddr_out_next;
        rst_reg       <= rst_next;
        mpa_reg       <= mpa_next;
        mst_reg       <= mst_next;
    end

`ifndef SYNTHESIS
    a_top_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg[2:0] == 3'b000) else $error("break not 8-byte aligned");
    a_top_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, top_reg} <= CEIL) else $error("break beyond arena");
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !we) else $error("tag write while idle");
    a_grant_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && mst_reg == ST_OK && mpa_reg != 16'd0 |->
            mpa_reg[2:0] == 3'b000 && {2'b00, mpa_reg} >= HDR)
        else $error("granted address malformed");
`endif

endmodule

/* sv/ffha_tag_ram.sv */
// Boundary-tag store: one tag per 8-byte granule, one write and one registered read port.
module ffha_tag_ram #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  ffha_pkg::tag_t       wdata,
    input  logic [AW-1:0]        raddr,
    output ffha_pkg::tag_t       rdata
);
    import ffha_pkg::*;

    tag_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sim/first_fit_heap_allocator_checker.sv */
// Checker for the first-fit heap allocator: watches every channel, predicts results, compares.
module first_fit_heap_allocator_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_kind,
    input  logic [16:0]       s_request_bytes,
    input  logic [15:0]       s_free_address,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [15:0]       m_payload_address,
    input  ffha_pkg::status_t m_status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [16:0]       cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int unsigned HDR   = 32;
    localparam int unsigned DEPTH = 8192;

    typedef struct {
        logic [15:0] addr;
        status_t     status;
    } grant_t;

    // Model state: block list in address order.
    bit          blk_free[$];
    int unsigned blk_size[$];
    int unsigned brk;
    int unsigned limit_reg;
    grant_t      grants_due[$];

    function automatic int unsigned ceiling_of();
        return (limit_reg > 65536) ? 65536 : limit_reg;
    endfunction

    function automatic grant_t allocate(int unsigned req);
        grant_t g;
        int unsigned need, start, sz;
        g.addr = '0;
        if (req == 0) begin
            g.status = ST_ZERO;
            return g;
        end
        need = (req + 7) & ~32'd7;
        start = 0;
        for (int k = 0; k < blk_size.size(); k++) begin
            sz = blk_size[k];
            if (blk_free[k] && sz >= need) begin
                // split only when a header plus 8 bytes remain and the store has room
                if (sz - need >= HDR + 8 && blk_size.size() < DEPTH) begin
                    blk_size.insert(k + 1, sz - need - HDR);
                    blk_free.insert(k + 1, 1'b1);
                    blk_size[k] = need;
                end
                blk_free[k] = 1'b0;
                g.addr = 16'(start + HDR);
                g.status = ST_OK;
                return g;
            end
            start += HDR + sz;
        end
        if (blk_size.size() >= DEPTH || brk + HDR + need > ceiling_of()) begin
            g.status = ST_NOSPACE;
            return g;
        end
        blk_size.push_back(need);
        blk_free.push_back(1'b0);
        g.addr = 16'(brk + HDR);
        g.status = ST_OK;
        brk += HDR + need;
        return g;
    endfunction

    function automatic grant_t release_block(int unsigned addr);
        grant_t g;
        int unsigned start, psz;
        int k;
        g.addr = '0;
        start = 0;
        for (k = 0; k < blk_size.size(); k++) begin
            if (start + HDR == addr && !blk_free[k]) break;
            start += HDR + blk_size[k];
        end
        if (k >= blk_size.size()) begin
            g.status = ST_BADFREE;
            return g;
        end
        g.status = ST_OK;
        blk_free[k] = 1'b1;
        if (k + 1 < blk_size.size() && blk_free[k + 1]) begin
            blk_size[k] = blk_size[k] + blk_size[k + 1] + HDR;
            blk_size.delete(k + 1);
            blk_free.delete(k + 1);
        end
        if (k > 0 && blk_free[k - 1]) begin
            psz = blk_size[k - 1];
            start -= HDR + psz;
            blk_size[k - 1] = psz + blk_size[k] + HDR;
            blk_size.delete(k);
            blk_free.delete(k);
            k--;
        end
        if (k + 1 == blk_size.size()) begin
            blk_size.delete(k);
            blk_free.delete(k);
            brk = start;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, result_count);
        fail_count++;
    endtask

    assign pending_count = grants_due.size();

    always @(posedge aclk) begin
        grant_t g;
        if (!aresetn) begin
            blk_free.delete();
            blk_size.delete();
            grants_due.delete();
            brk = 0;
            limit_reg = 65536;
            fail_count = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) limit_reg = cfg_data;
            // compare the output before queuing the item accepted on the same edge
            if (m_valid && m_ready) begin
                result_count++;
                if (grants_due.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    g = grants_due.pop_front();
                    if (m_payload_address !== g.addr)
                        report_mismatch("payload_address", m_payload_address, g.addr);
                    if (m_status !== g.status)
                        report_mismatch("status", m_status, g.status);
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind) g = release_block(s_free_address);
                else        g = allocate(s_request_bytes);
                grants_due.push_back(g);
            end
        end
    end
endmodule

/* sim/first_fit_heap_allocator_test.sv */
// Testbench top for the first-fit heap allocator: stimulus, idling and verdict.
module first_fit_heap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_kind = 1'b0;
    logic [16:0]       s_request_bytes = '0;
    logic [15:0]       s_free_address = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [15:0]       m_payload_address;
    status_t           m_status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [16:0]       cfg_data = '0;
    int                fail_count;
    int                pending_count;
    int                result_count;
    int                cycle_count = 0;
    int                items_sent = 0;
    bit                drain_on = 1'b0;

    // Addresses granted so far, kept for well-formed frees.
    logic [15:0]       granted[$];

    localparam int CYCLE_LIMIT = 2000000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    first_fit_heap_allocator dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_request_bytes, .s_free_address,
        .m_valid, .m_ready, .m_payload_address, .m_status,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    first_fit_heap_allocator_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_request_bytes, .s_free_address,
        .m_valid, .m_ready, .m_payload_address, .m_status,
        .cfg_valid, .cfg_ready, .cfg_data,
        .fail_count, .pending_count, .result_count
    );

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[first_fit_heap_allocator] ERROR");
            $finish;
        end
    end

    // Harvest granted addresses as they transfer out.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_status == ST_OK && m_payload_address != 0)
            granted.push_back(m_payload_address);
    end

    // Receiver: draw a stall per result, drop ready for it, then hold ready for one transfer.
    initial begin : receiver
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = drain_on ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Valid stays high after a transfer so a zero gap follows back to back;
    // a gap or settle() drops it.
    task automatic send_item(input logic kind, input logic [16:0] req, input logic [15:0] fa,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_request_bytes <= req;
        s_free_address <= fa;
        @(posedge aclk iff s_ready);
        items_sent++;
    endtask

    task automatic send_alloc(input logic [16:0] req);
        send_item(1'b0, req, 16'($urandom), $urandom_range(0, 13));
    endtask

    task automatic send_free(input logic [15:0] fa);
        send_item(1'b1, 17'($urandom), fa, $urandom_range(0, 13));
    endtask

    // Drop valid, wait until every expected result has transferred, then let the walker settle.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk iff pending_count == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [16:0] lim);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Free every address still held so the heap returns to empty.
    task automatic free_all();
        int idx;
        settle();
        while (granted.size() > 0) begin
            idx = $urandom_range(0, granted.size() - 1);
            send_free(granted[idx]);
            granted.delete(idx);
        end
        settle();
    endtask

    function automatic logic [16:0] small_request();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 17'($urandom_range(1, 200));
        if (r < 9) return 17'($urandom_range(1, 2048));
        return 17'($urandom);
    endfunction

    initial begin : stimulus
        int idx, pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-heap frees, zero request, extremes, split, merge, bad frees.
        send_free(16'd0);
        send_free(16'hFFFF);
        send_alloc(17'd0);
        send_alloc(17'h1FFFF);
        send_alloc(17'd65536);
        send_alloc(17'd1);
        send_alloc(17'd8);
        send_alloc(17'd9);
        send_alloc(17'd100);
        send_alloc(17'd64);
        settle();
        send_free(granted[1] + 16'd8);   // interior offset
        send_free(granted[1] + 16'd1);   // misaligned
        send_free(granted[1]);           // free a middle block
        send_free(granted[1]);           // already free
        send_free(granted[0]);           // merge with free successor
        send_alloc(17'd8);               // first fit with split of merged block
        send_free(granted[3]);           // neither neighbour is free, so no merge
        send_free(16'hFFF0);             // past the break
        settle();
        write_limit(17'd0);
        send_alloc(17'd8);               // reuses a free block even under a zero limit
        write_limit(17'd65536);
        free_all();
        granted.delete();
        send_alloc(17'd65504);           // fills the arena exactly
        send_alloc(17'd1);               // no room
        free_all();

        // Random phases across several limits, extremes among them.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_limit(17'd65536);
                1: write_limit(17'h1FFFF);
                2: write_limit(17'($urandom_range(64, 4096)));
                3: write_limit(17'($urandom_range(0, 40)));
                4: write_limit(17'($urandom_range(4096, 65536)));
                default: write_limit(17'd65536);
            endcase
            for (int n = 0; n < 160; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_alloc(small_request());
                end else if (pick < 85 && granted.size() > 0) begin
                    idx = $urandom_range(0, granted.size() - 1);
                    send_free(granted[idx]);
                    granted.delete(idx);
                end else if (pick < 92) begin
                    send_free(16'($urandom));
                end else if (pick < 96) begin
                    send_alloc(17'($urandom));
                end else begin
                    send_alloc(17'd0);
                end
            end
            if (phase == 2) begin
                // lower the limit under a live break, then keep going
                write_limit(17'd32);
                for (int n = 0; n < 20; n++) send_alloc(small_request());
            end
            free_all();
        end

        drain_on = 1'b1;
        settle();
        $display("run covered %0d items and %0d results over six limit settings",
                 items_sent, result_count);
        $display("directed edges, split and merge paths, invalid frees and random traffic");
        if (fail_count == 0 && pending_count == 0) begin
            $display("[first_fit_heap_allocator] OK");
        end else begin
            $display("[first_fit_heap_allocator] ERROR");
        end
        $finish;
    end
endmodule
